>>> hdl/greedy_block_load_rebalancer_defines.svh
// ----------------------------------------------------------------------------
// greedy block load rebalancer assertion macros
// shorthand for the checker: same-cycle and next-cycle implications
// ----------------------------------------------------------------------------
`ifndef GREEDY_BLOCK_LOAD_REBALANCER_DEFINES_SVH
`define GREEDY_BLOCK_LOAD_REBALANCER_DEFINES_SVH

// consequent holds in the cycle of the antecedent
`define GBLR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define GBLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gblr_pkg.sv
// ----------------------------------------------------------------------------
// gblr_pkg
// shared types, codes and widths of the greedy block load rebalancer
// ----------------------------------------------------------------------------
`default_nettype none

package gblr_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int MAX_RANKS_DEF  = 16;

  localparam int OP_W       = 2;
  localparam int OWNER_W    = 4;
  localparam int WEIGHT_W   = 24;
  localparam int SUM_W      = 32;
  localparam int CFG_W      = 5;
  localparam int STATUS_W   = 3;
  localparam int BLK_OUT_W  = 8;
  localparam int RANK_OUT_W = 4;

  localparam logic [CFG_W-1:0] RANK_COUNT_RST = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED  = 3'd0,
    ST_LOADED   = 3'd1,
    ST_MOVED    = 3'd2,
    ST_BALANCED = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LD0,
    S_LD1,
    S_RSCAN,
    S_RWAIT,
    S_CHECK,
    S_BSCAN,
    S_BWAIT,
    S_MV0,
    S_MV1,
    S_MV2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    take;
    logic    clr;
    logic    ld_blk;
    logic    ld_upd;
    logic    scan_init;
    logic    rk_rd;
    logic    chk;
    logic    blk_rd;
    logic    mv_rd_src;
    logic    mv_src_upd;
    logic    mv_dst_upd;
    logic    res_set;
    status_t res_code;
    logic    res_ranks;
    logic    res_blk;
    logic    emit;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ld_bad;
    logic one_rank;
    logic rank_last;
    logic balanced;
    logic no_blocks;
    logic blk_last;
    logic found;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/gblr_ctrl.sv
// ----------------------------------------------------------------------------
// gblr_ctrl
// sequencer: decodes an item and steps the datapath through its scans
// ----------------------------------------------------------------------------
`default_nettype none

module gblr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gblr_pkg::dp_sts_t  sts,
  output gblr_pkg::ctl_cmd_t cmd
);
  import gblr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_CLEAR: state_nxt = S_EMIT;
          OP_LOAD:  state_nxt = sts.ld_bad ? S_EMIT : S_LD0;
          OP_STEP:  state_nxt = sts.one_rank ? S_EMIT : S_RSCAN;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_LD0:   state_nxt = S_LD1;
      S_LD1:   state_nxt = S_EMIT;
      S_RSCAN: state_nxt = sts.rank_last ? S_RWAIT : S_RSCAN;
      S_RWAIT: state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.balanced) begin
          state_nxt = S_EMIT;
        end else if (sts.no_blocks) begin
          state_nxt = S_BWAIT;
        end else begin
          state_nxt = S_BSCAN;
        end
      end
      S_BSCAN: state_nxt = sts.blk_last ? S_BWAIT : S_BSCAN;
      S_BWAIT: state_nxt = S_MV0;
      S_MV0:   state_nxt = sts.found ? S_MV1 : S_EMIT;
      S_MV1:   state_nxt = S_MV2;
      S_MV2:   state_nxt = S_EMIT;
      S_EMIT:  state_nxt = sts.out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_CLEAR: begin
            cmd.clr      = 1'b1;
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_CLEARED;
          end
          OP_LOAD: begin
            if (sts.ld_bad) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = ST_REJECTED;
            end
          end
          OP_STEP: begin
            if (sts.one_rank) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = ST_BALANCED;
            end else begin
              cmd.scan_init = 1'b1;
            end
          end
          default: cmd.res_set = 1'b0;
        endcase
      end
      S_LD0: cmd.ld_blk = 1'b1;
      S_LD1: begin
        cmd.ld_upd   = 1'b1;
        cmd.res_set  = 1'b1;
        cmd.res_code = ST_LOADED;
      end
      S_RSCAN: cmd.rk_rd = 1'b1;
      S_RWAIT: cmd.rk_rd = 1'b0;
      S_CHECK: begin
        cmd.chk = 1'b1;
        if (sts.balanced) begin
          cmd.res_set   = 1'b1;
          cmd.res_code  = ST_BALANCED;
          cmd.res_ranks = 1'b1;
        end
      end
      S_BSCAN: cmd.blk_rd = 1'b1;
      S_BWAIT: cmd.blk_rd = 1'b0;
      S_MV0: begin
        if (sts.found) begin
          cmd.mv_rd_src = 1'b1;
        end else begin
          cmd.res_set   = 1'b1;
          cmd.res_code  = ST_BALANCED;
          cmd.res_ranks = 1'b1;
        end
      end
      S_MV1: cmd.mv_src_upd = 1'b1;
      S_MV2: begin
        cmd.mv_dst_upd = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_code   = ST_MOVED;
        cmd.res_ranks  = 1'b1;
        cmd.res_blk    = 1'b1;
      end
      S_EMIT:  cmd.emit = sts.out_free;
      default: cmd.emit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/gblr_dpath.sv
// ----------------------------------------------------------------------------
// gblr_dpath
// block table, rank totals, scan registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module gblr_dpath #(
  parameter int MAX_BLOCKS = gblr_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_RANKS  = gblr_pkg::MAX_RANKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [gblr_pkg::CFG_W-1:0]      cfg_rank_count,
  input  logic [gblr_pkg::OP_W-1:0]       in_operation,
  input  logic [gblr_pkg::OWNER_W-1:0]    in_owner_rank,
  input  logic [gblr_pkg::WEIGHT_W-1:0]   in_work_weight,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [gblr_pkg::STATUS_W-1:0]   out_status,
  output logic [gblr_pkg::BLK_OUT_W-1:0]  out_moved_block,
  output logic [gblr_pkg::RANK_OUT_W-1:0] out_source_rank,
  output logic [gblr_pkg::RANK_OUT_W-1:0] out_dest_rank,
  input  gblr_pkg::ctl_cmd_t              cmd,
  output gblr_pkg::dp_sts_t               sts
);
  import gblr_pkg::*;

  localparam int RW = $clog2(MAX_RANKS);
  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int NW = $clog2(MAX_RANKS + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;
  localparam int PW = SUM_W + NW;

  logic [CFG_W-1:0]    rank_count_r;
  logic [OP_W-1:0]     item_op_r;
  logic [OWNER_W-1:0]  item_owner_r;
  logic [WEIGHT_W-1:0] item_weight_r;

  logic [SUM_W-1:0]    rk_mem [MAX_RANKS];
  logic [MAX_RANKS-1:0] rk_vld_r;
  logic [SUM_W-1:0]    rk_q_r;
  logic [RW-1:0]       bo_mem [MAX_BLOCKS];
  logic [WEIGHT_W-1:0] bw_mem [MAX_BLOCKS];
  logic [RW-1:0]       bo_q_r;
  logic [WEIGHT_W-1:0] bw_q_r;

  logic [SUM_W-1:0]    sum_r;
  logic [LW-1:0]       loaded_r;
  logic [RW-1:0]       rcnt_r;
  logic [BW-1:0]       bcnt_r;
  logic                rk_sv_r;
  logic [RW-1:0]       rk_si_r;
  logic                bv_r;
  logic [BW-1:0]       bi_r;

  logic [SUM_W-1:0]    max_r;
  logic [SUM_W-1:0]    min_r;
  logic [RW-1:0]       src_r;
  logic [RW-1:0]       dst_r;
  logic [SUM_W-1:0]    diff_r;
  logic                found_r;
  logic [WEIGHT_W-1:0] best_w_r;
  logic [BW-1:0]       best_i_r;

  status_t             res_code_r;
  logic                res_ranks_r;
  logic                res_blk_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [BLK_OUT_W-1:0]  out_moved_r;
  logic [RANK_OUT_W-1:0] out_src_r;
  logic [RANK_OUT_W-1:0] out_dst_r;

  logic [CW-1:0]       cnt_ext;
  logic [CW-1:0]       n_sel;
  logic [NW-1:0]       n_act;
  logic [RW-1:0]       owner_idx;
  logic [PW-1:0]       max_prod;
  logic [PW-1:0]       min_prod;
  logic [PW-1:0]       sum_ext;
  logic                rk_re;
  logic [RW-1:0]       rk_ra;
  logic                rk_we;
  logic [RW-1:0]       rk_wa;
  logic [SUM_W-1:0]    rk_wd;
  logic                bo_we;
  logic [BW-1:0]       bo_wa;
  logic [RW-1:0]       bo_wd;
  logic                cand;
  logic                out_free;

  // active rank count: zero reads as one, large values saturate
  assign cnt_ext   = CW'(rank_count_r);
  assign n_sel     = (cnt_ext == '0) ? CW'(1) :
                     ((cnt_ext > CW'(MAX_RANKS)) ? CW'(MAX_RANKS) : cnt_ext);
  assign n_act     = NW'(n_sel);
  assign owner_idx = RW'(item_owner_r);

  assign max_prod = PW'(max_r) * PW'(n_act);
  assign min_prod = PW'(min_r) * PW'(n_act);
  assign sum_ext  = PW'(sum_r);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts           = '0;
    sts.op        = op_t'(item_op_r);
    sts.ld_bad    = (CW'(item_owner_r) >= n_sel) || (loaded_r == LW'(MAX_BLOCKS));
    sts.one_rank  = (n_act == NW'(1));
    sts.rank_last = (rcnt_r == RW'(n_act - NW'(1)));
    sts.balanced  = (max_prod == sum_ext) || (min_prod == sum_ext);
    sts.no_blocks = (loaded_r == '0);
    sts.blk_last  = (bcnt_r == BW'(loaded_r - LW'(1)));
    sts.found     = found_r;
    sts.out_free  = out_free;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r <= RANK_COUNT_RST;
    end else if (cfg_valid) begin
      rank_count_r <= cfg_rank_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_op_r     <= in_operation;
      item_owner_r  <= in_owner_rank;
      item_weight_r <= in_work_weight;
    end
  end

  // rank total memory ports
  always_comb begin
    rk_re = cmd.ld_blk || cmd.rk_rd || cmd.mv_rd_src || cmd.mv_src_upd;
    if (cmd.ld_blk) begin
      rk_ra = owner_idx;
    end else if (cmd.mv_rd_src) begin
      rk_ra = src_r;
    end else if (cmd.mv_src_upd) begin
      rk_ra = dst_r;
    end else begin
      rk_ra = rcnt_r;
    end
    rk_we = cmd.ld_upd || cmd.mv_src_upd || cmd.mv_dst_upd;
    if (cmd.ld_upd) begin
      rk_wa = owner_idx;
      rk_wd = rk_q_r + SUM_W'(item_weight_r);
    end else if (cmd.mv_src_upd) begin
      rk_wa = src_r;
      rk_wd = rk_q_r - SUM_W'(best_w_r);
    end else begin
      rk_wa = dst_r;
      rk_wd = rk_q_r + SUM_W'(best_w_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
    if (rk_re) rk_q_r <= rk_vld_r[rk_ra] ? rk_mem[rk_ra] : '0;
  end

  // entries not written since clear read as zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      rk_vld_r <= '0;
    end else if (rk_we) begin
      rk_vld_r[rk_wa] <= 1'b1;
    end
  end

  // block table
  assign bo_we = cmd.ld_blk || cmd.mv_dst_upd;
  assign bo_wa = cmd.ld_blk ? BW'(loaded_r) : best_i_r;
  assign bo_wd = cmd.ld_blk ? owner_idx : dst_r;

  always_ff @(posedge clk) begin
    if (bo_we) bo_mem[bo_wa] <= bo_wd;
    if (cmd.ld_blk) bw_mem[BW'(loaded_r)] <= item_weight_r;
    if (cmd.blk_rd) begin
      bo_q_r <= bo_mem[bcnt_r];
      bw_q_r <= bw_mem[bcnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      sum_r    <= '0;
      loaded_r <= '0;
    end else if (cmd.ld_upd) begin
      sum_r    <= sum_r + SUM_W'(item_weight_r);
      loaded_r <= loaded_r + LW'(1);
    end
  end

  // scan counters and read pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_sv_r <= 1'b0;
      bv_r    <= 1'b0;
    end else begin
      rk_sv_r <= cmd.rk_rd;
      bv_r    <= cmd.blk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      rcnt_r <= '0;
    end else if (cmd.rk_rd) begin
      rcnt_r <= rcnt_r + RW'(1);
    end
    if (cmd.chk) begin
      bcnt_r <= '0;
    end else if (cmd.blk_rd) begin
      bcnt_r <= bcnt_r + BW'(1);
    end
    rk_si_r <= rcnt_r;
    bi_r    <= bcnt_r;
  end

  // busiest and laziest rank, first index kept on ties
  always_ff @(posedge clk) begin
    if (rk_sv_r) begin
      if (rk_si_r == '0) begin
        max_r <= rk_q_r;
        min_r <= rk_q_r;
        src_r <= '0;
        dst_r <= '0;
      end else begin
        if (rk_q_r > max_r) begin
          max_r <= rk_q_r;
          src_r <= rk_si_r;
        end
        if (rk_q_r < min_r) begin
          min_r <= rk_q_r;
          dst_r <= rk_si_r;
        end
      end
    end
    if (cmd.chk) diff_r <= max_r - min_r;
  end

  // heaviest block of the busiest rank under half the gap, lowest index on ties
  assign cand = bv_r && (bo_q_r == src_r) &&
                (SUM_W'({bw_q_r, 1'b0}) < diff_r) &&
                (!found_r || (bw_q_r > best_w_r));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chk) begin
      found_r <= 1'b0;
    end else if (cand) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      best_w_r <= bw_q_r;
      best_i_r <= bi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_code_r  <= cmd.res_code;
      res_ranks_r <= cmd.res_ranks;
      res_blk_r   <= cmd.res_blk;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_code_r;
      out_moved_r  <= res_blk_r ? BLK_OUT_W'(best_i_r) : '0;
      out_src_r    <= res_ranks_r ? RANK_OUT_W'(src_r) : '0;
      out_dst_r    <= res_ranks_r ? RANK_OUT_W'(dst_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_moved_block = out_moved_r;
  assign out_source_rank = out_src_r;
  assign out_dest_rank   = out_dst_r;

endmodule

`default_nettype wire

>>> hdl/greedy_block_load_rebalancer.sv
// ----------------------------------------------------------------------------
// greedy_block_load_rebalancer
// Keeps a table of work blocks with owner ranks and weights plus per-rank
// totals, and moves at most one block from the busiest to the laziest rank per step.
// Input channel in_*: valid/stall, one item (clear, load or step) per transfer.
// Result channel out_*: valid/stall, one result per clear, load or step item;
// the unused operation code is taken and gives no result.
// Config channel cfg_*: valid/ready, rank count, always ready; write only
// while the block is idle.
// One item is worked at a time. A step with two or more active ranks scans the
// ranks, one rank total memory read per cycle, then the loaded blocks, one
// block table read per cycle for the candidate scan.
// Reset clears totals, sum, block count and rank count to 16; no clearing
// pass, totals carry valid bits. A stalled result holds in the output
// register; the next item is still taken, and its result waits for the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_block_load_rebalancer #(
  parameter int MAX_BLOCKS = gblr_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_RANKS  = gblr_pkg::MAX_RANKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gblr_pkg::CFG_W-1:0]      cfg_rank_count,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gblr_pkg::OP_W-1:0]       in_operation,
  input  logic [gblr_pkg::OWNER_W-1:0]    in_owner_rank,
  input  logic [gblr_pkg::WEIGHT_W-1:0]   in_work_weight,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gblr_pkg::STATUS_W-1:0]   out_status,
  output logic [gblr_pkg::BLK_OUT_W-1:0]  out_moved_block,
  output logic [gblr_pkg::RANK_OUT_W-1:0] out_source_rank,
  output logic [gblr_pkg::RANK_OUT_W-1:0] out_dest_rank
);
  import gblr_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  gblr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gblr_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_RANKS  (MAX_RANKS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_rank_count  (cfg_rank_count),
    .in_operation    (in_operation),
    .in_owner_rank   (in_owner_rank),
    .in_work_weight  (in_work_weight),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_moved_block (out_moved_block),
    .out_source_rank (out_source_rank),
    .out_dest_rank   (out_dest_rank),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

>>> hdl/gblr_chk.sv
// ----------------------------------------------------------------------------
// gblr_chk
// port-level checks of the rebalancer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_block_load_rebalancer_defines.svh"

module gblr_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [gblr_pkg::CFG_W-1:0]      cfg_rank_count,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [gblr_pkg::OP_W-1:0]       in_operation,
  input logic [gblr_pkg::OWNER_W-1:0]    in_owner_rank,
  input logic [gblr_pkg::WEIGHT_W-1:0]   in_work_weight,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [gblr_pkg::STATUS_W-1:0]   out_status,
  input logic [gblr_pkg::BLK_OUT_W-1:0]  out_moved_block,
  input logic [gblr_pkg::RANK_OUT_W-1:0] out_source_rank,
  input logic [gblr_pkg::RANK_OUT_W-1:0] out_dest_rank
);
  import gblr_pkg::*;

  // one item in work at a time
  `GBLR_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "item taken while busy")

  `GBLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_moved_block), "stalled result changed")

  `GBLR_ASSERT_SAME(a_move_ranks, out_valid && (out_status == ST_MOVED), out_source_rank != out_dest_rank, "move within one rank")

  `GBLR_ASSERT_SAME(a_block_zero, out_valid && (out_status != ST_MOVED), out_moved_block == '0, "block index without move")

  `GBLR_ASSERT_SAME(a_ranks_zero, out_valid && (out_status == ST_CLEARED || out_status == ST_LOADED || out_status == ST_REJECTED), (out_source_rank == '0) && (out_dest_rank == '0), "ranks on table result")

endmodule

bind greedy_block_load_rebalancer gblr_chk u_chk (.*);

`default_nettype wire

>>> tb/greedy_block_load_rebalancer_test.sv
// ----------------------------------------------------------------------------
// greedy_block_load_rebalancer_test
// Self-checking bench for the greedy block load rebalancer. A predictor keeps
// its own block table, rank totals and rank count. Each accepted clear, load
// or step item gives an expected result, checked field by field at transfer.
// Directed items cover field extremes, rejects, rank count limits, tied and
// balanced totals, a full table and a long output hold-off. Random traffic
// then runs clear/load/step sequences under several idling patterns.
// ----------------------------------------------------------------------------
module greedy_block_load_rebalancer_test;
  import gblr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_BLOCKS      = MAX_BLOCKS_DEF;
  localparam int N_RANKS       = MAX_RANKS_DEF;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 600;

  typedef struct packed {
    status_t                 status;
    logic [BLK_OUT_W-1:0]    blk;
    logic [RANK_OUT_W-1:0]   src;
    logic [RANK_OUT_W-1:0]   dst;
  } rebal_result_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_rank_count = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation   = '0;
  logic [OWNER_W-1:0]    in_owner_rank  = '0;
  logic [WEIGHT_W-1:0]   in_work_weight = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [BLK_OUT_W-1:0]  out_moved_block;
  logic [RANK_OUT_W-1:0] out_source_rank;
  logic [RANK_OUT_W-1:0] out_dest_rank;

  // predictor state
  logic [OWNER_W-1:0]  pred_owner  [N_BLOCKS];
  logic [WEIGHT_W-1:0] pred_weight [N_BLOCKS];
  logic [SUM_W-1:0]    pred_total  [N_RANKS];
  logic [SUM_W-1:0]    pred_sum;
  int                  pred_blocks;
  logic [CFG_W-1:0]    pred_rank_cfg;

  rebal_result_t pending_results[$];
  rebal_result_t want;

  int  gap_pct   = 0;
  int  stall_pct = 0;
  bit  hold_req  = 1'b0;
  int  hold_left = 0;
  int  idle_cycles = 0;

  int  fail_count      = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  moves_seen      = 0;
  int  rejects_seen    = 0;
  int  cfg_writes      = 0;

  greedy_block_load_rebalancer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_rank_count  (cfg_rank_count),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_owner_rank   (in_owner_rank),
    .in_work_weight  (in_work_weight),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_moved_block (out_moved_block),
    .out_source_rank (out_source_rank),
    .out_dest_rank   (out_dest_rank)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit rebalance_predict(input logic [OP_W-1:0] op,
                                           input logic [OWNER_W-1:0] owner,
                                           input logic [WEIGHT_W-1:0] weight,
                                           output rebal_result_t res);
    int n;
    int src;
    int dst;
    int best;
    bit found;
    logic [SUM_W-1:0] diff;
    logic [63:0] hi_prod;
    logic [63:0] lo_prod;
    res = '0;
    n = (pred_rank_cfg == 0) ? 1 :
        (int'(pred_rank_cfg) > N_RANKS) ? N_RANKS : int'(pred_rank_cfg);
    if (op == OP_CLEAR) begin
      for (int r = 0; r < N_RANKS; r++) pred_total[r] = '0;
      pred_sum = '0;
      pred_blocks = 0;
      res.status = ST_CLEARED;
      return 1'b1;
    end
    if (op == OP_LOAD) begin
      if (int'(owner) >= n || pred_blocks >= N_BLOCKS) begin
        res.status = ST_REJECTED;
        return 1'b1;
      end
      pred_owner[pred_blocks]  = owner;
      pred_weight[pred_blocks] = weight;
      pred_blocks++;
      pred_total[owner] = pred_total[owner] + SUM_W'(weight);
      pred_sum = pred_sum + SUM_W'(weight);
      res.status = ST_LOADED;
      return 1'b1;
    end
    if (op == OP_STEP) begin
      res.status = ST_BALANCED;
      if (n == 1) return 1'b1;
      src = 0;
      dst = 0;
      for (int r = 1; r < n; r++) begin
        if (pred_total[r] > pred_total[src]) src = r;
        if (pred_total[r] < pred_total[dst]) dst = r;
      end
      res.src = RANK_OUT_W'(src);
      res.dst = RANK_OUT_W'(dst);
      hi_prod = {32'd0, pred_total[src]} * 64'(n);
      lo_prod = {32'd0, pred_total[dst]} * 64'(n);
      if (hi_prod == {32'd0, pred_sum} || lo_prod == {32'd0, pred_sum}) return 1'b1;
      diff = pred_total[src] - pred_total[dst];
      found = 1'b0;
      best = 0;
      for (int b = 0; b < pred_blocks; b++) begin
        if (int'(pred_owner[b]) != src) continue;
        if (({8'd0, pred_weight[b]} << 1) >= diff) continue;
        if (!found || pred_weight[b] > pred_weight[best]) begin
          best = b;
          found = 1'b1;
        end
      end
      if (!found) return 1'b1;
      pred_total[src] = pred_total[src] - SUM_W'(pred_weight[best]);
      pred_total[dst] = pred_total[dst] + SUM_W'(pred_weight[best]);
      pred_owner[best] = OWNER_W'(dst);
      res.status = ST_MOVED;
      res.blk = BLK_OUT_W'(best);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [OWNER_W-1:0] owner,
                           input logic [WEIGHT_W-1:0] weight);
    rebal_result_t res;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_owner_rank  <= owner;
    in_work_weight <= weight;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (rebalance_predict(op, owner, weight, res)) pending_results = {pending_results, res};
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // an unused-code item gives no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rank_count(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_rank_count <= value;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_rank_cfg = value;
    cfg_writes++;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight(input int profile);
    case (profile)
      0:       return WEIGHT_W'($urandom_range(0, 7));
      1:       return WEIGHT_W'($urandom_range(0, 1000));
      2:       return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF
                                                  : WEIGHT_W'($urandom_range(0, 3));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_rank_count();
    case ($urandom_range(0, 7))
      0:       return 5'd1;
      1:       return 5'd2;
      2:       return 5'd3;
      3:       return 5'd16;
      4:       return 5'd0;
      5:       return 5'd17;
      6:       return 5'd31;
      default: return CFG_W'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic test_directed_ops();
    gap_pct = 0;
    stall_pct = 0;
    send_item(OP_STEP, 4'd0, 24'd0);
    send_item(OP_LOAD, 4'd15, 24'hFFFFFF);
    send_item(OP_LOAD, 4'd0, 24'd0);
    send_item(OP_LOAD, 4'd15, 24'd1);
    send_item(OP_LOAD, 4'd15, 24'h555555);
    send_item(OP_LOAD, 4'd15, 24'hAAAAAA);
    send_item(OP_LOAD, 4'd7, 24'h123456);
    repeat (4) send_item(OP_STEP, 4'd0, 24'd0);
    send_item(OP_UNUSED, 4'hA, 24'h5A5A5A);
    send_item(OP_CLEAR, 4'hF, 24'hFFFFFF);
    send_item(OP_STEP, 4'd0, 24'd0);
    // two equal heavy ranks, nothing small enough to move
    send_item(OP_LOAD, 4'd0, 24'hFFFFFF);
    send_item(OP_LOAD, 4'd1, 24'hFFFFFF);
    send_item(OP_STEP, 4'd0, 24'd0);
    wait_idle();
  endtask

  task automatic test_rank_limits();
    set_rank_count(5'd4);
    send_item(OP_LOAD, 4'd5, 24'd50);
    send_item(OP_LOAD, 4'd3, 24'd100);
    send_item(OP_LOAD, 4'd0, 24'd10);
    send_item(OP_LOAD, 4'd3, 24'd20);
    repeat (2) send_item(OP_STEP, 4'd0, 24'd0);
    // totals of rank 3 stay but fall out of the scan
    set_rank_count(5'd2);
    send_item(OP_STEP, 4'd0, 24'd0);
    send_item(OP_LOAD, 4'd2, 24'd1);
    send_item(OP_CLEAR, 4'd0, 24'd0);
    send_item(OP_LOAD, 4'd0, 24'd5);
    send_item(OP_LOAD, 4'd1, 24'd5);
    send_item(OP_STEP, 4'd0, 24'd0);
    send_item(OP_CLEAR, 4'd0, 24'd0);
    send_item(OP_LOAD, 4'd0, 24'd10);
    send_item(OP_LOAD, 4'd1, 24'd0);
    send_item(OP_STEP, 4'd0, 24'd0);
    set_rank_count(5'd1);
    send_item(OP_STEP, 4'd0, 24'd0);
    send_item(OP_LOAD, 4'd0, 24'd7);
    send_item(OP_LOAD, 4'd1, 24'd7);
    set_rank_count(5'd0);
    send_item(OP_STEP, 4'd0, 24'd0);
    send_item(OP_LOAD, 4'd1, 24'd3);
    set_rank_count(5'd31);
    send_item(OP_LOAD, 4'd15, 24'd9);
    send_item(OP_STEP, 4'd0, 24'd0);
    set_rank_count(5'd17);
    send_item(OP_STEP, 4'd0, 24'd0);
    set_rank_count(5'd16);
  endtask

  task automatic test_table_full();
    send_item(OP_CLEAR, 4'd0, 24'd0);
    for (int i = 0; i < N_BLOCKS - 1; i++) begin
      send_item(OP_LOAD, OWNER_W'($urandom_range(1, 15)), pick_weight($urandom_range(0, 3)));
    end
    // last slot goes to rank 0 and fills the table, so the next load is rejected
    send_item(OP_LOAD, 4'd0, 24'd1);
    send_item(OP_LOAD, 4'd3, 24'd1);
    repeat (3) send_item(OP_STEP, 4'd0, 24'd0);
    wait_idle();
  endtask

  task automatic test_output_hold();
    send_item(OP_CLEAR, 4'd0, 24'd0);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      if (i % 3 == 2) send_item(OP_STEP, 4'd0, 24'd0);
      else send_item(OP_LOAD, OWNER_W'($urandom_range(0, 15)), pick_weight(1));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_items, input int gap, input int stall);
    int cnt;
    int k;
    int s;
    int m;
    int profile;
    int n;
    logic [OP_W-1:0] op;
    cnt = 0;
    gap_pct = gap;
    stall_pct = stall;
    while (cnt < n_items) begin
      case ($urandom_range(0, 99)) inside
        [0:11]: set_rank_count(pick_rank_count());
        [12:84]: begin
          n = (pred_rank_cfg == 0) ? 1 :
              (int'(pred_rank_cfg) > N_RANKS) ? N_RANKS : int'(pred_rank_cfg);
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
          s = $urandom_range(1, k + 2);
          profile = $urandom_range(0, 3);
          send_item(OP_CLEAR, OWNER_W'($urandom), WEIGHT_W'($urandom));
          for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 9) == 0)
              send_item(OP_LOAD, OWNER_W'($urandom_range(0, 15)), pick_weight(profile));
            else
              send_item(OP_LOAD, OWNER_W'($urandom_range(0, n - 1)), pick_weight(profile));
          end
          for (int i = 0; i < s; i++) send_item(OP_STEP, OWNER_W'($urandom), WEIGHT_W'($urandom));
          cnt += 1 + k + s;
        end
        default: begin
          m = $urandom_range(1, 6);
          for (int i = 0; i < m; i++) begin
            op = OP_W'($urandom_range(0, 3));
            send_item(op, OWNER_W'($urandom), WEIGHT_W'($urandom));
            if (op != OP_UNUSED) cnt++;
          end
        end
      endcase
    end
    wait_idle();
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", out_status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == ST_MOVED) moves_seen++;
        if (want.status == ST_REJECTED) rejects_seen++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_moved_block !== want.blk) begin
          $error("moved_block: expected %0d, got %0d", want.blk, out_moved_block);
          fail_count++;
        end
        if (out_source_rank !== want.src) begin
          $error("source_rank: expected %0d, got %0d", want.src, out_source_rank);
          fail_count++;
        end
        if (out_dest_rank !== want.dst) begin
          $error("dest_rank: expected %0d, got %0d", want.dst, out_dest_rank);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
        $display("greedy_block_load_rebalancer_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    pred_rank_cfg = RANK_COUNT_RST;
    pred_sum = '0;
    pred_blocks = 0;
    for (int r = 0; r < N_RANKS; r++) pred_total[r] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_rank_limits();
    test_table_full();
    test_output_hold();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 54, 0);
    test_random_traffic(240, 0, 54);
    test_random_traffic(240, 36, 36);
    wait_idle();
    $display("covered %0d items: %0d results checked, %0d block moves, %0d rejected loads",
             items_sent, results_checked, moves_seen, rejects_seen);
    $display("%0d rank count writes, full table, long output hold-off, four idling mixes",
             cfg_writes);
    if (fail_count == 0) begin
      $display("greedy_block_load_rebalancer_test OK");
    end else begin
      $display("greedy_block_load_rebalancer_test NOT OK");
    end
    $finish;
  end

endmodule
